FILE: hw/rtl/bezier_path_point_generator_assert.svh
// Assertion macros for the Bezier point generator port checks.
`ifndef BEZIER_PATH_POINT_GENERATOR_ASSERT_SVH
`define BEZIER_PATH_POINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define BPG_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpg: port property violated");

// Next-cycle implication, masked while reset is high.
`define BPG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpg: port property violated");

`endif

FILE: hw/rtl/bpg_pkg.sv
package bpg_pkg;

   localparam int COORD_W    = 16;
   localparam int T_W        = 17;            // Q0.16 plus one integer bit
   localparam int CNT_W      = 7;
   localparam int IDX_W      = 6;
   localparam int REM_W      = 7;
   localparam int A_W        = 32;            // first de Casteljau level
   localparam int B_W        = 48;            // second level
   localparam int OPND_W     = 48;
   localparam int ACC_W      = 64;
   localparam int PROD_W     = T_W + COORD_W;
   localparam int STEP_W     = 5;
   localparam int DIV_CNT_W  = $clog2(T_W);

   localparam logic [T_W-1:0]     T_ONE      = 17'h1_0000;
   localparam logic [ACC_W-1:0]   ROUND_BIAS = 64'h0000_8000_0000_0000;
   localparam logic [COORD_W-1:0] SIGN_FLIP  = 16'h8000;

   localparam logic [STEP_W-1:0] UOP_LAST_CUBIC = 5'd19;
   localparam logic [STEP_W-1:0] UOP_LAST_QUAD  = 5'd7;

   typedef enum logic [1:0] {
      SRC_P,
      SRC_A,
      SRC_B
   } src_lvl_type;

   typedef enum logic [1:0] {
      DST_A,
      DST_B,
      DST_RES
   } dst_lvl_type;

   typedef struct packed {
      logic        use_t;
      src_lvl_type src_lvl;
      logic [1:0]  src_idx;
      logic [1:0]  digit;
      logic [1:0]  shift;
      logic        first;
      logic        last;
      dst_lvl_type dst_lvl;
      logic [1:0]  dst_idx;
   } uop_type;

   typedef struct packed {
      dst_lvl_type dst_lvl;
      logic [1:0]  dst_idx;
      logic        axis;
      logic        first;
      logic        last;
      logic        round;
   } tag_type;

   // Multiply-accumulate program for one coordinate.
   // Cubic: three first-level blends, two second-level, one final.
   // Quadratic: two first-level blends, then the final one scaled by 2^16.
   function automatic uop_type uop_decode(input logic cubic, input logic [STEP_W-1:0] step);
      uop_type             u;
      logic [STEP_W-1:0]   s;
      logic [STEP_W-1:0]   l1_len;
      logic [STEP_W-1:0]   l2_len;
      u      = '0;
      s      = '0;
      l1_len = cubic ? 5'd6 : 5'd4;
      l2_len = cubic ? 5'd8 : 5'd4;
      if (step < l1_len) begin
         u.use_t   = step[0];
         u.src_lvl = SRC_P;
         u.src_idx = step[2:1] + {1'b0, step[0]};
         u.digit   = 2'd0;
         u.shift   = 2'd0;
         u.first   = ~step[0];
         u.last    = step[0];
         u.dst_lvl = DST_A;
         u.dst_idx = step[2:1];
      end else if (step < l1_len + l2_len) begin
         s         = step - l1_len;
         u.use_t   = s[1];
         u.src_lvl = SRC_A;
         u.src_idx = {1'b0, s[2]} + {1'b0, s[1]};
         u.digit   = {1'b0, s[0]};
         u.shift   = {1'b0, s[0]} + (cubic ? 2'd0 : 2'd1);
         u.first   = (s[1:0] == 2'd0);
         u.last    = (s[1:0] == 2'd3);
         u.dst_lvl = cubic ? DST_B : DST_RES;
         u.dst_idx = {1'b0, s[2]};
      end else begin
         s         = step - 5'd14;
         u.use_t   = (s >= 5'd3);
         u.src_lvl = SRC_B;
         u.src_idx = {1'b0, u.use_t};
         u.digit   = u.use_t ? 2'(s - 5'd3) : s[1:0];
         u.shift   = u.digit;
         u.first   = (s == 5'd0);
         u.last    = (s == 5'd5);
         u.dst_lvl = DST_RES;
         u.dst_idx = 2'd0;
      end
      return u;
   endfunction

endpackage

FILE: hw/rtl/bpg_req_if.sv
interface bpg_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [bpg_pkg::COORD_W-1:0]  p0_x;
   logic signed [bpg_pkg::COORD_W-1:0]  p0_y;
   logic signed [bpg_pkg::COORD_W-1:0]  p1_x;
   logic signed [bpg_pkg::COORD_W-1:0]  p1_y;
   logic signed [bpg_pkg::COORD_W-1:0]  p2_x;
   logic signed [bpg_pkg::COORD_W-1:0]  p2_y;
   logic signed [bpg_pkg::COORD_W-1:0]  p3_x;
   logic signed [bpg_pkg::COORD_W-1:0]  p3_y;
   logic [bpg_pkg::CNT_W-1:0]           point_count;

   modport source (
      output valid, func, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
      input  ready
   );

   modport sink (
      input  valid, func, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
      output ready
   );
endinterface

FILE: hw/rtl/bpg_rsp_if.sv
interface bpg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bpg_pkg::COORD_W-1:0]  out_x;
   logic signed [bpg_pkg::COORD_W-1:0]  out_y;
   logic [bpg_pkg::IDX_W-1:0]           sample_index;
   logic                                last;

   modport source (
      output valid, out_x, out_y, sample_index, last,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, sample_index, last,
      output ready
   );
endinterface

FILE: hw/rtl/bpg_div.sv
// Restoring divider for 2^16 / divisor, one quotient bit per cycle.
module bpg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bpg_pkg::REM_W-1:0]   divisor,
   output logic                        done,
   output logic [bpg_pkg::T_W-1:0]     quotient,
   output logic [bpg_pkg::REM_W-1:0]   remainder
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [bpg_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bpg_pkg::REM_W-1:0]       dvs_ff, dvs_in;
   logic [bpg_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [bpg_pkg::T_W-1:0]         quo_ff, quo_in;
   logic [bpg_pkg::REM_W:0]         trial;
   logic                            fits;
   logic                            num_bit;

   always_comb begin
      num_bit = bpg_pkg::T_ONE[bpg_pkg::DIV_CNT_W'(bpg_pkg::T_W - 1) - cnt_ff];
      trial   = {rem_ff, num_bit};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? bpg_pkg::REM_W'(trial - {1'b0, dvs_ff}) : trial[bpg_pkg::REM_W-1:0];
         quo_in = {quo_ff[bpg_pkg::T_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bpg_pkg::DIV_CNT_W'(bpg_pkg::T_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/bpg_mac.sv
// Shared 17x16 multiplier with a registered product, then a 64-bit
// shift-and-accumulate stage that reports the finished sum.
module bpg_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue,
   input  logic [bpg_pkg::T_W-1:0]       coef,
   input  logic [bpg_pkg::COORD_W-1:0]   digit,
   input  logic [1:0]                    shift,
   input  bpg_pkg::tag_type              tag,
   output logic                          wb_valid,
   output bpg_pkg::tag_type              wb_tag,
   output logic [bpg_pkg::ACC_W-1:0]     wb_value
);

   logic                          valid_ff;
   logic [bpg_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [1:0]                    shift_ff;
   bpg_pkg::tag_type              tag_ff;
   logic [bpg_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [bpg_pkg::ACC_W-1:0]     addend;
   logic [bpg_pkg::ACC_W-1:0]     base;

   always_comb begin
      prod_in = bpg_pkg::PROD_W'(coef) * bpg_pkg::PROD_W'(digit);
      addend  = bpg_pkg::ACC_W'(prod_ff) << {shift_ff, 4'b0000};
      if (tag_ff.first) begin
         base = tag_ff.round ? bpg_pkg::ROUND_BIAS : '0;
      end else begin
         base = acc_ff;
      end
      acc_in = base + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift;
      tag_ff   <= tag;
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign wb_valid = valid_ff && tag_ff.last;
   assign wb_tag   = tag_ff;
   assign wb_value = acc_in;

endmodule

FILE: hw/rtl/bezier_path_point_generator.sv
// Quadratic / cubic Bezier point generator. Each request word carries the
// control points, the degree select and a point count n (clamped to
// MAX_POINTS); the block answers with n point words at t = i/(n-1), each
// with its sample index and a last flag on the final point, and a count of
// zero gives no words at all. Points come from an exact integer de Casteljau
// evaluation, rounded to nearest with halves upward. All products run
// through one 17x16 multiplier with a registered product and a 64-bit
// accumulator under a small microcode sequencer: a point costs 20
// multiplies per coordinate in cubic mode and 8 in quadratic mode, plus
// drain and handoff. A request of two or more points first passes through
// a bit-serial divider that finds the step of t. A new request is taken
// only once the last point is in the output register; that register lets
// the block go on with the next point while the previous one waits to be
// taken.
module bezier_path_point_generator #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   bpg_req_if.sink      req_bus,
   bpg_rsp_if.source    rsp_bus
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam int CW = bpg_pkg::COORD_W;

   // sequencer
   state_type                          state_ff, state_in;
   logic                               issuing_ff, issuing_in;
   logic [bpg_pkg::STEP_W-1:0]         step_ff, step_in;
   logic                               axis_ff, axis_in;
   logic                               cubic_ff, cubic_in;
   logic [bpg_pkg::CNT_W-1:0]          n_ff, n_in;
   logic [bpg_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [bpg_pkg::REM_W-1:0]          d_ff, d_in;

   // parameter walk: t advances by q0 + r0/d per point
   logic [bpg_pkg::T_W-1:0]            t_ff, t_in;
   logic [bpg_pkg::REM_W-1:0]          frac_ff, frac_in;
   logic [bpg_pkg::T_W-1:0]            q0_ff, q0_in;
   logic [bpg_pkg::REM_W-1:0]          r0_ff, r0_in;

   // operands and partial blends (coordinates held in offset binary)
   logic [CW-1:0]                      px_ff [4];
   logic [CW-1:0]                      py_ff [4];
   logic [bpg_pkg::A_W-1:0]            a_ff [3];
   logic [bpg_pkg::B_W-1:0]            b_ff [2];
   logic [CW-1:0]                      res_x_ff;
   logic [CW-1:0]                      res_y_ff;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]               out_x_ff;
   logic signed [CW-1:0]               out_y_ff;
   logic [bpg_pkg::IDX_W-1:0]          sidx_ff;
   logic                               last_ff;

   logic                               take;
   logic [bpg_pkg::CNT_W-1:0]          n_sel;
   logic                               div_start;
   logic                               div_done;
   logic [bpg_pkg::T_W-1:0]            div_quo;
   logic [bpg_pkg::REM_W-1:0]          div_rem;

   bpg_pkg::uop_type                   uop;
   logic                               issue;
   logic [bpg_pkg::STEP_W-1:0]         uop_last;
   logic [bpg_pkg::T_W-1:0]            mt;
   logic [bpg_pkg::T_W-1:0]            coef;
   logic [bpg_pkg::OPND_W-1:0]         opnd;
   logic [CW-1:0]                      digit;
   bpg_pkg::tag_type                   tag;
   logic                               wb_valid;
   bpg_pkg::tag_type                   wb_tag;
   logic [bpg_pkg::ACC_W-1:0]          wb_value;
   logic [CW-1:0]                      wb_coord;

   logic                               out_load;
   logic                               is_last;
   logic [bpg_pkg::REM_W:0]            frac_sum;
   logic                               frac_wrap;

   assign take  = req_bus.valid && req_bus.ready;
   assign n_sel = (32'(req_bus.point_count) > MAX_POINTS) ?
                  bpg_pkg::CNT_W'(MAX_POINTS) : req_bus.point_count;

   // ---------------------------------------------------------------------
   // Operand fetch: pick weight (t or 1-t) and one 16-bit digit of the
   // current operand for the shared multiplier.
   // ---------------------------------------------------------------------
   always_comb begin
      uop      = bpg_pkg::uop_decode(cubic_ff, step_ff);
      issue    = (state_ff == ST_RUN) && issuing_ff;
      uop_last = cubic_ff ? bpg_pkg::UOP_LAST_CUBIC : bpg_pkg::UOP_LAST_QUAD;
      mt       = bpg_pkg::T_ONE - t_ff;
      coef     = uop.use_t ? t_ff : mt;
      unique case (uop.src_lvl)
         bpg_pkg::SRC_P: begin
            opnd = bpg_pkg::OPND_W'(axis_ff ? py_ff[uop.src_idx] : px_ff[uop.src_idx]);
         end
         bpg_pkg::SRC_A: begin
            opnd = bpg_pkg::OPND_W'(a_ff[uop.src_idx]);
         end
         bpg_pkg::SRC_B: begin
            opnd = b_ff[uop.src_idx[0]];
         end
         default: begin
            opnd = '0;
         end
      endcase
      unique case (uop.digit)
         2'd0:    digit = opnd[CW-1:0];
         2'd1:    digit = opnd[2*CW-1:CW];
         2'd2:    digit = opnd[3*CW-1:2*CW];
         default: digit = '0;
      endcase
      tag.dst_lvl = uop.dst_lvl;
      tag.dst_idx = uop.dst_idx;
      tag.axis    = axis_ff;
      tag.first   = uop.first;
      tag.last    = uop.last;
      tag.round   = (uop.dst_lvl == bpg_pkg::DST_RES);
   end

   bpg_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .coef     (coef),
      .digit    (digit),
      .shift    (uop.shift),
      .tag      (tag),
      .wb_valid (wb_valid),
      .wb_tag   (wb_tag),
      .wb_value (wb_value)
   );

   bpg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (d_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Top 16 bits of the rounded sum, back from offset binary.
   assign wb_coord = wb_value[bpg_pkg::ACC_W-1 -: CW] ^ bpg_pkg::SIGN_FLIP;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
      is_last   = (idx_ff == n_ff - 1'b1);
      frac_sum  = {1'b0, frac_ff} + {1'b0, r0_ff};
      frac_wrap = (frac_sum >= {1'b0, d_ff});

      state_in   = state_ff;
      issuing_in = issuing_ff;
      step_in    = step_ff;
      axis_in    = axis_ff;
      cubic_in   = cubic_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      d_in       = d_ff;
      t_in       = t_ff;
      frac_in    = frac_ff;
      q0_in      = q0_ff;
      r0_in      = r0_ff;
      div_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cubic_in = req_bus.func;
               n_in     = n_sel;
               d_in     = n_sel - 1'b1;
               frac_in  = (n_sel - 1'b1) >> 1;
               t_in     = '0;
               idx_in   = '0;
               step_in  = '0;
               axis_in  = 1'b0;
               // drop an empty request, skip the divider for a single point
               if (n_sel == '0) begin
                  state_in = ST_IDLE;
               end else if (n_sel == bpg_pkg::CNT_W'(1)) begin
                  q0_in      = '0;
                  r0_in      = '0;
                  issuing_in = 1'b1;
                  state_in   = ST_RUN;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q0_in      = div_quo;
               r0_in      = div_rem;
               issuing_in = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            // walk the program once for x, then once for y
            if (issue) begin
               if (step_ff == uop_last) begin
                  step_in = '0;
                  if (axis_ff) begin
                     issuing_in = 1'b0;
                  end else begin
                     axis_in = 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            if (wb_valid && (wb_tag.dst_lvl == bpg_pkg::DST_RES) && wb_tag.axis) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register frees up, then advance t
            if (out_load) begin
               t_in    = t_ff + q0_ff + bpg_pkg::T_W'(frac_wrap);
               frac_in = frac_wrap ? bpg_pkg::REM_W'(frac_sum - {1'b0, d_ff})
                                   : frac_sum[bpg_pkg::REM_W-1:0];
               idx_in  = idx_ff + 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in    = '0;
                  axis_in    = 1'b0;
                  issuing_in = 1'b1;
                  state_in   = ST_RUN;
               end
            end
         end
         default: begin
            state_in   = ST_IDLE;
            issuing_in = 1'b0;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      axis_ff  <= axis_in;
      cubic_ff <= cubic_in;
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      d_ff     <= d_in;
      t_ff     <= t_in;
      frac_ff  <= frac_in;
      q0_ff    <= q0_in;
      r0_ff    <= r0_in;

      // capture control points in offset binary
      if (take) begin
         px_ff[0] <= $unsigned(req_bus.p0_x) ^ bpg_pkg::SIGN_FLIP;
         py_ff[0] <= $unsigned(req_bus.p0_y) ^ bpg_pkg::SIGN_FLIP;
         px_ff[1] <= $unsigned(req_bus.p1_x) ^ bpg_pkg::SIGN_FLIP;
         py_ff[1] <= $unsigned(req_bus.p1_y) ^ bpg_pkg::SIGN_FLIP;
         px_ff[2] <= $unsigned(req_bus.p2_x) ^ bpg_pkg::SIGN_FLIP;
         py_ff[2] <= $unsigned(req_bus.p2_y) ^ bpg_pkg::SIGN_FLIP;
         px_ff[3] <= $unsigned(req_bus.p3_x) ^ bpg_pkg::SIGN_FLIP;
         py_ff[3] <= $unsigned(req_bus.p3_y) ^ bpg_pkg::SIGN_FLIP;
      end

      // write back finished blends
      if (wb_valid) begin
         unique case (wb_tag.dst_lvl)
            bpg_pkg::DST_A: begin
               a_ff[wb_tag.dst_idx] <= wb_value[bpg_pkg::A_W-1:0];
            end
            bpg_pkg::DST_B: begin
               b_ff[wb_tag.dst_idx[0]] <= wb_value[bpg_pkg::B_W-1:0];
            end
            bpg_pkg::DST_RES: begin
               if (wb_tag.axis) begin
                  res_y_ff <= wb_coord;
               end else begin
                  res_x_ff <= wb_coord;
               end
            end
            default: begin
            end
         endcase
      end

      if (out_load) begin
         out_x_ff <= $signed(res_x_ff);
         out_y_ff <= $signed(res_y_ff);
         sidx_ff  <= idx_ff[bpg_pkg::IDX_W-1:0];
         last_ff  <= is_last;
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_x        = out_x_ff;
   assign rsp_bus.out_y        = out_y_ff;
   assign rsp_bus.sample_index = sidx_ff;
   assign rsp_bus.last         = last_ff;

endmodule

FILE: hw/rtl/bpg_checker.sv
`include "bezier_path_point_generator_assert.svh"

module bpg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [bpg_pkg::CNT_W-1:0]     req_point_count,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bpg_pkg::COORD_W-1:0]   rsp_out_x,
   input logic [bpg_pkg::COORD_W-1:0]   rsp_out_y,
   input logic [bpg_pkg::IDX_W-1:0]     rsp_sample_index,
   input logic                          rsp_last
);

   // a non-empty request leaves the block busy in the cycle after the take
   `BPG_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready && (req_point_count != '0), !req_ready)

   // an idle block never holds a point from the middle of a run
   `BPG_ASSERT_NOW(a_idle_no_partial, clock, reset, req_ready, !(rsp_valid && !rsp_last))

   // the first point of a new run never shows up the cycle after the take
   `BPG_ASSERT_NEXT(a_no_early_point, clock, reset, req_valid && req_ready, !rsp_valid || rsp_last)

   // a stalled result word holds
   `BPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_sample_index) && $stable(rsp_last))

endmodule

bind bezier_path_point_generator bpg_checker u_bpg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_point_count  (req_bus.point_count),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_out_x        (rsp_bus.out_x),
   .rsp_out_y        (rsp_bus.out_y),
   .rsp_sample_index (rsp_bus.sample_index),
   .rsp_last         (rsp_bus.last)
);

FILE: verif/bezier_point_checker.sv
module bezier_point_checker #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic  clock,
   input  logic  reset,
   bpg_req_if    req_bus,
   bpg_rsp_if    rsp_bus,
   output int    mismatch_count,
   output int    points_waiting,
   output int    points_checked,
   output int    quad_requests,
   output int    cubic_requests
);

   typedef struct packed {
      logic signed [bpg_pkg::COORD_W-1:0] x;
      logic signed [bpg_pkg::COORD_W-1:0] y;
      logic [bpg_pkg::IDX_W-1:0]          index;
      logic                               last;
   } curve_point_type;

   curve_point_type expected_points[$];

   // Round the Q.48 sum to nearest (halves up), clamp, drop the offset.
   function automatic logic [bpg_pkg::COORD_W-1:0] settle_coord(input bit [63:0] acc);
      bit [63:0] r;
      r = (acc + bpg_pkg::ROUND_BIAS) >> 48;
      if (r > 64'hFFFF) r = 64'hFFFF;
      return r[bpg_pkg::COORD_W-1:0] ^ bpg_pkg::SIGN_FLIP;
   endfunction

   // pts[0..7] = p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   function automatic void predict_curve_points(
         input logic                                  cubic,
         input logic [7:0][bpg_pkg::COORD_W-1:0]      pts,
         input logic [bpg_pkg::CNT_W-1:0]             count);
      bit [63:0]       n;
      bit [63:0]       t;
      bit [63:0]       mt;
      bit [63:0]       acc_x;
      bit [63:0]       acc_y;
      bit [63:0]       w [4];
      curve_point_type pt;
      n = count;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (bit [63:0] i = 0; i < n; i++) begin
         t = (n > 1) ? (i * bpg_pkg::T_ONE + (n - 1) / 2) / (n - 1) : 64'd0;
         if (t > bpg_pkg::T_ONE) t = bpg_pkg::T_ONE;
         mt = bpg_pkg::T_ONE - t;
         if (cubic) begin
            w[0] = mt * mt * mt;
            w[1] = 64'd3 * mt * mt * t;
            w[2] = 64'd3 * mt * t * t;
            w[3] = t * t * t;
         end else begin
            w[0] = (mt * mt) << 16;
            w[1] = (64'd2 * t * mt) << 16;
            w[2] = (t * t) << 16;
            w[3] = 64'd0;
         end
         acc_x = 64'd0;
         acc_y = 64'd0;
         for (int k = 0; k < 4; k++) begin
            acc_x += w[k] * 64'(pts[2*k] ^ bpg_pkg::SIGN_FLIP);
            acc_y += w[k] * 64'(pts[2*k+1] ^ bpg_pkg::SIGN_FLIP);
         end
         pt.x     = settle_coord(acc_x);
         pt.y     = settle_coord(acc_y);
         pt.index = i[bpg_pkg::IDX_W-1:0];
         pt.last  = (i + 1 == n);
         expected_points.insert(expected_points.size(), pt);
      end
   endfunction

   task automatic report_field(input string what, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      curve_point_type want;
      if (reset) begin
         expected_points.delete();
         mismatch_count = 0;
         points_checked = 0;
         quad_requests  = 0;
         cubic_requests = 0;
      end else begin
         // check the outgoing word first: it can never belong to a request taken this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point word, expected none, got x=%0d y=%0d idx=%0d",
                        $time, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.sample_index);
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.out_x !== want.x) report_field("out_x", want.x, rsp_bus.out_x);
               if (rsp_bus.out_y !== want.y) report_field("out_y", want.y, rsp_bus.out_y);
               if (rsp_bus.sample_index !== want.index)
                  report_field("sample_index", want.index, rsp_bus.sample_index);
               if (rsp_bus.last !== want.last) report_field("last", want.last, rsp_bus.last);
               points_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_curve_points(req_bus.func,
                                 {req_bus.p3_y, req_bus.p3_x, req_bus.p2_y, req_bus.p2_x,
                                  req_bus.p1_y, req_bus.p1_x, req_bus.p0_y, req_bus.p0_x},
                                 req_bus.point_count);
            if (req_bus.func) cubic_requests++;
            else quad_requests++;
         end
      end
      points_waiting = expected_points.size();
   end

endmodule

FILE: verif/tb.sv
module tb;

   // curve degree codes carried in the func field
   localparam logic CURVE_QUAD  = 1'b0;
   localparam logic CURVE_CUBIC = 1'b1;

   localparam logic signed [bpg_pkg::COORD_W-1:0] C_MAX  = 16'sh7FFF;
   localparam logic signed [bpg_pkg::COORD_W-1:0] C_MIN  = 16'sh8000;
   localparam logic signed [bpg_pkg::COORD_W-1:0] C_ZERO = 16'sh0000;
   localparam logic signed [bpg_pkg::COORD_W-1:0] C_ONE  = 16'sh0001;
   localparam logic signed [bpg_pkg::COORD_W-1:0] C_NEG1 = 16'shFFFF;

   localparam int RANDOM_WORDS = 116;
   localparam int PHASES       = 4;

   // one request word as the sender sees it; pts[0..7] = p0_x .. p3_y
   typedef struct packed {
      logic                                func;
      logic [bpg_pkg::CNT_W-1:0]           count;
      logic [7:0][bpg_pkg::COORD_W-1:0]    pts;
   } bezier_req_type;

   logic clock;
   logic reset;

   bpg_req_if req_bus ();
   bpg_rsp_if rsp_bus ();

   int idle_pct;
   int stall_pct;

   int mismatch_count;
   int points_waiting;
   int points_checked;
   int quad_requests;
   int cubic_requests;

   bezier_path_point_generator #(
      .MAX_POINTS (64)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // The checker watches both channels, predicts every point of each accepted
   // request and compares; it only hands its counts back to this module.
   bezier_point_checker #(
      .MAX_POINTS (64)
   ) point_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .points_waiting (points_waiting),
      .points_checked (points_checked),
      .quad_requests  (quad_requests),
      .cubic_requests (cubic_requests)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run: the slowest clean run is every word a 64-point cubic
   // request, under 150 words; allow several times that.
   initial begin
      #40_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver side: drop ready at random, at the rate the current phase sets.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic bezier_req_type make_req(
         input logic                          func,
         input logic [bpg_pkg::COORD_W-1:0]   p0x, p0y, p1x, p1y,
         input logic [bpg_pkg::COORD_W-1:0]   p2x, p2y, p3x, p3y,
         input logic [bpg_pkg::CNT_W-1:0]     count);
      bezier_req_type w;
      w.func  = func;
      w.count = count;
      w.pts   = {p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x};
      return w;
   endfunction

   // Mostly full-range values, with the rails and values near zero mixed in.
   function automatic logic [bpg_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return C_MAX;
         1: return C_MIN;
         2: return bpg_pkg::COORD_W'($urandom_range(0, 16) - 8);
         default: return bpg_pkg::COORD_W'($urandom);
      endcase
   endfunction

   // Keep most runs short so the run stays fast; a few hit and pass the clamp.
   function automatic logic [bpg_pkg::CNT_W-1:0] rand_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      else if (r < 64) return bpg_pkg::CNT_W'($urandom_range(1, 8));
      else if (r < 84) return bpg_pkg::CNT_W'($urandom_range(9, 40));
      else if (r < 92) return bpg_pkg::CNT_W'($urandom_range(41, 64));
      else return bpg_pkg::CNT_W'($urandom_range(65, 127));
   endfunction

   // Present one word at the falling edge, hold it until it is taken at a
   // rising edge, then return on the next falling edge. Valid stays high into
   // the next word unless the sender decides to idle.
   task automatic send_request(input bezier_req_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.func        = w.func;
      req_bus.point_count = w.count;
      req_bus.p0_x        = w.pts[0];
      req_bus.p0_y        = w.pts[1];
      req_bus.p1_x        = w.pts[2];
      req_bus.p1_y        = w.pts[3];
      req_bus.p2_x        = w.pts[4];
      req_bus.p2_y        = w.pts[5];
      req_bus.p3_x        = w.pts[6];
      req_bus.p3_y        = w.pts[7];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_idle [PHASES];
      int phase_stall[PHASES];
      phase_idle  = '{0, 61, 0, 15};
      phase_stall = '{0, 0, 61, 15};

      // hold every input at a known value through reset
      reset               = 1'b1;
      idle_pct            = 0;
      stall_pct           = 0;
      req_bus.valid       = 1'b0;
      req_bus.func        = CURVE_QUAD;
      req_bus.point_count = '0;
      req_bus.p0_x        = '0;
      req_bus.p0_y        = '0;
      req_bus.p1_x        = '0;
      req_bus.p1_y        = '0;
      req_bus.p2_x        = '0;
      req_bus.p2_y        = '0;
      req_bus.p3_x        = '0;
      req_bus.p3_y        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words, no idling. Single-point runs return p0 alone.
      send_request(make_req(CURVE_QUAD, C_MAX, C_MIN, C_ZERO, C_ZERO,
                            C_MIN, C_MAX, C_ZERO, C_ZERO, 7'd1));
      send_request(make_req(CURVE_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN,
                            C_ZERO, C_ONE, C_MAX, C_MAX, 7'd1));
      // zero count: no point words at all
      send_request(make_req(CURVE_QUAD, C_ONE, C_ONE, C_ONE, C_ONE,
                            C_ONE, C_ONE, C_ONE, C_ONE, 7'd0));
      send_request(make_req(CURVE_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX,
                            C_MAX, C_MAX, C_MAX, C_MAX, 7'd0));
      // two points: endpoints only, must be exact
      send_request(make_req(CURVE_QUAD, C_MIN, C_MAX, C_MAX, C_MIN,
                            C_MAX, C_MIN, C_MIN, C_MAX, 7'd2));
      send_request(make_req(CURVE_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX,
                            C_MAX, C_MIN, C_MIN, C_MAX, 7'd2));
      // midpoint halves: +0.5 rounds up, -0.5 rounds toward zero
      send_request(make_req(CURVE_QUAD, C_ZERO, C_ZERO, C_ONE, C_NEG1,
                            C_ZERO, C_ZERO, C_MAX, C_MIN, 7'd3));
      send_request(make_req(CURVE_CUBIC, C_ZERO, C_ZERO, C_ONE, C_NEG1,
                            C_ONE, C_NEG1, C_ZERO, C_ZERO, 7'd3));
      send_request(make_req(CURVE_CUBIC, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                            C_ZERO, C_ZERO, C_ONE, C_NEG1, 7'd5));
      // full-length runs on the rails
      send_request(make_req(CURVE_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN,
                            C_MIN, C_MAX, C_MAX, C_MIN, 7'd64));
      send_request(make_req(CURVE_QUAD, C_MAX, C_MAX, C_MAX, C_MAX,
                            C_MAX, C_MAX, C_MIN, C_MIN, 7'd64));
      send_request(make_req(CURVE_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN,
                            C_MIN, C_MIN, C_MIN, C_MIN, 7'd64));
      // counts past the limit clamp to the full run
      send_request(make_req(CURVE_QUAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(), 7'd127));
      send_request(make_req(CURVE_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(), 7'd65));
      send_request(make_req(CURVE_QUAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(), 7'd100));
      // quadratic with a busy p3 that must be ignored
      send_request(make_req(CURVE_QUAD, C_ONE, C_NEG1, C_MAX, C_MIN,
                            C_NEG1, C_ONE, C_MAX, C_MAX, 7'd5));

      // Random words across the idling mixes: none, sender only, receiver
      // only, both lightly.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
            send_request(make_req(1'($urandom_range(0, 1)),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  rand_count()));
         end
      end
      req_bus.valid = 1'b0;

      // drain: every predicted point must come out, then let the block settle
      while (points_waiting != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Covered %0d quadratic and %0d cubic requests, %0d curve points checked,",
               quad_requests, cubic_requests, points_checked);
      $display("under no idling, sender gaps, receiver stalls and both together.");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bpg_pkg.sv
hw/rtl/bpg_req_if.sv
hw/rtl/bpg_rsp_if.sv
hw/rtl/bpg_div.sv
hw/rtl/bpg_mac.sv
hw/rtl/bezier_path_point_generator.sv
hw/rtl/bpg_checker.sv
verif/bezier_point_checker.sv
verif/tb.sv
